// ===== rtl/cnms_pkg.sv =====
// shared types and constants for the canny non-maximum suppression block
package cnms_pkg;

   localparam int MAG_W      = 16;
   localparam int CLASS_W    = 2;
   localparam int CFG_W      = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int HEIGHT_MAX = 1024;
   localparam int ROW_W      = 10;

   // q8 tangents of 22.5 and 67.5 degrees
   localparam int TAN_LO_Q8 = 106;
   localparam int TAN_HI_Q8 = 618;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_L2       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESH  = 3'd4;

   localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_WEAK   = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd2;

   typedef enum logic [1:0] {
      SEC_HORZ = 2'd0,
      SEC_VERT = 2'd1,
      SEC_DIAG = 2'd2,
      SEC_ANTI = 2'd3
   } sector_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic root_start;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic use_l2;
      logic root_busy;
   } status_type;

endpackage

// ===== rtl/cnms_sqrt.sv =====
// iterative integer square root, two radicand bits per cycle
module cnms_sqrt
   import cnms_pkg::*;
#(
   parameter int RW = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2*RW-1:0]   radicand,
   output logic              busy,
   output logic [RW-1:0]     root
);

   localparam int CNT_W = $clog2(RW + 1);

   logic [2*RW-1:0] rad_ff, rad_in;
   logic [RW+1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [RW+1:0]   rem_shift;
   logic [RW+1:0]   trial;

   always_comb begin
      rem_shift = {rem_ff[RW-1:0], rad_ff[2*RW-1 -: 2]};
      trial     = {root_ff, 2'b01};
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[2*RW-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== rtl/cnms_dp.sv =====
// datapath: magnitude, sector, line buffers, window and classification
module cnms_dp
   import cnms_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int GRAD_BITS = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [GRAD_BITS-1:0]   grad_x,
   input  logic [GRAD_BITS-1:0]   grad_y,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   result_valid,
   output logic [MAG_W-1:0]       kept_magnitude,
   output logic [CLASS_W-1:0]     edge_class,
   output logic                   frame_last
);

   localparam int AW  = GRAD_BITS;
   localparam int RW  = AW + 1;
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int XW  = (WW > CFG_W) ? WW : CFG_W;
   localparam int SW  = (RW > MAG_W) ? RW : MAG_W + 1;
   localparam int TW  = AW + 10;

   // configuration
   logic [CFG_W-1:0] width_ff, height_ff;
   logic             use_l2_ff;
   logic [MAG_W-1:0] low_ff, high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(640);
         height_ff <= CFG_W'(480);
         use_l2_ff <= 1'b0;
         low_ff    <= MAG_W'(20);
         high_ff   <= MAG_W'(60);
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[CFG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data[CFG_W-1:0];
            CSR_USE_L2:       use_l2_ff <= csr_data[0];
            CSR_LOW_THRESH:   low_ff    <= csr_data;
            CSR_HIGH_THRESH:  high_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic [XW-1:0]    w_eff;
   logic [CFG_W-1:0] h_eff;

   always_comb begin
      if (XW'(width_ff) < XW'(3)) begin
         w_eff = XW'(3);
      end else if (XW'(width_ff) > XW'(MAX_WIDTH)) begin
         w_eff = XW'(MAX_WIDTH);
      end else begin
         w_eff = XW'(width_ff);
      end
      if (height_ff < CFG_W'(3)) begin
         h_eff = CFG_W'(3);
      end else if (height_ff > CFG_W'(HEIGHT_MAX)) begin
         h_eff = CFG_W'(HEIGHT_MAX);
      end else begin
         h_eff = height_ff;
      end
   end

   // raster position
   logic [CW-1:0]    col_ff, col_in, col_cur_ff, col_eff;
   logic [ROW_W-1:0] row_ff, row_in, row_cur_ff, row_eff;
   logic             pre_wrap;
   logic [CFG_W-1:0] row_step;
   logic [XW-1:0]    col_next;
   logic [CFG_W-1:0] row_next;

   always_comb begin
      pre_wrap = XW'(col_ff) >= w_eff;
      col_eff  = pre_wrap ? '0 : col_ff;
      row_step = CFG_W'(row_ff) + CFG_W'(pre_wrap);
      row_eff  = (row_step >= h_eff) ? '0 : row_step[ROW_W-1:0];

      col_next = XW'(col_cur_ff) + XW'(1);
      row_next = CFG_W'(row_cur_ff) + CFG_W'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (cmd.finish) begin
         if (col_next >= w_eff) begin
            col_in = '0;
            row_in = (row_next >= h_eff) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[CW-1:0];
            row_in = row_cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
      if (cmd.load) begin
         col_cur_ff <= col_eff;
         row_cur_ff <= row_eff;
      end
   end

   // gradient capture
   logic [AW-1:0] ax_ff, ay_ff;
   logic          nx_ff, ny_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         nx_ff <= grad_x[AW-1];
         ny_ff <= grad_y[AW-1];
         ax_ff <= grad_x[AW-1] ? (~grad_x + 1'b1) : grad_x;
         ay_ff <= grad_y[AW-1] ? (~grad_y + 1'b1) : grad_y;
      end
   end

   // squares, l1 sum and sector
   logic [2*AW-1:0] sqx_ff, sqy_ff;
   logic [AW:0]     l1_ff;
   sector_type      sec_ff, sec_calc;
   logic [TW-1:0]   ty, tlo, thi;

   always_comb begin
      ty  = TW'(ay_ff) << 8;
      tlo = TW'(ax_ff) * TW'(TAN_LO_Q8);
      thi = TW'(ax_ff) * TW'(TAN_HI_Q8);
      if (ay_ff == '0 || ty < tlo) begin
         sec_calc = SEC_HORZ;
      end else if (ty >= thi) begin
         sec_calc = SEC_VERT;
      end else if (nx_ff == ny_ff) begin
         sec_calc = SEC_DIAG;
      end else begin
         sec_calc = SEC_ANTI;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         sqx_ff <= ax_ff * ax_ff;
         sqy_ff <= ay_ff * ay_ff;
         l1_ff  <= (AW+1)'(ax_ff) + (AW+1)'(ay_ff);
         sec_ff <= sec_calc;
      end
   end

   logic [RW-1:0]   root;
   logic            root_busy;
   logic [2*RW-1:0] radicand;

   assign radicand = (2*RW)'(sqx_ff) + (2*RW)'(sqy_ff);

   cnms_sqrt #(.RW(RW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (radicand),
      .busy     (root_busy),
      .root     (root)
   );

   assign status.use_l2    = use_l2_ff;
   assign status.root_busy = root_busy;

   logic [SW-1:0]    mag_wide;
   logic [MAG_W-1:0] mag;

   always_comb begin
      mag_wide = use_l2_ff ? SW'(root) : SW'(l1_ff);
      mag      = (mag_wide > SW'(16'hFFFF)) ? 16'hFFFF : mag_wide[MAG_W-1:0];
   end

   // line buffers
   logic [MAG_W-1:0] line0_mem [MAX_WIDTH];
   logic [MAG_W-1:0] line1_mem [MAX_WIDTH];
   sector_type       sec_mem   [MAX_WIDTH];
   logic [MAG_W-1:0] line0_rd_ff, line1_rd_ff;
   sector_type       sec_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         line0_rd_ff <= line0_mem[col_eff];
      end
      if (cmd.finish) begin
         line0_mem[col_cur_ff] <= mag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         line1_rd_ff <= line1_mem[col_eff];
      end
      if (cmd.finish) begin
         line1_mem[col_cur_ff] <= line0_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sec_rd_ff <= sec_mem[col_eff];
      end
      if (cmd.finish) begin
         sec_mem[col_cur_ff] <= sec_ff;
      end
   end

   // window: middle and right columns, rows top to bottom
   logic [MAG_W-1:0] win_mid_ff [3];
   logic [MAG_W-1:0] win_rgt_ff [3];
   sector_type       sec_dly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            win_mid_ff[r] <= '0;
            win_rgt_ff[r] <= '0;
         end
         sec_dly_ff <= SEC_HORZ;
      end else if (cmd.finish) begin
         for (int r = 0; r < 3; r++) begin
            win_mid_ff[r] <= win_rgt_ff[r];
         end
         win_rgt_ff[0] <= line1_rd_ff;
         win_rgt_ff[1] <= line0_rd_ff;
         win_rgt_ff[2] <= mag;
         sec_dly_ff    <= sec_rd_ff;
      end
   end

   // suppression and classification on the shifted window
   logic [MAG_W-1:0]   ctr, nb_a, nb_b;
   logic               cur_valid, cur_inner, cur_last, keep;
   logic [MAG_W-1:0]   kept;
   logic [CLASS_W-1:0] cls;

   always_comb begin
      ctr = win_rgt_ff[1];
      case (sec_dly_ff)
         SEC_HORZ: begin
            nb_a = win_mid_ff[1];
            nb_b = line0_rd_ff;
         end
         SEC_VERT: begin
            nb_a = win_rgt_ff[0];
            nb_b = win_rgt_ff[2];
         end
         SEC_DIAG: begin
            nb_a = win_mid_ff[0];
            nb_b = mag;
         end
         default: begin
            nb_a = line1_rd_ff;
            nb_b = win_mid_ff[2];
         end
      endcase
      cur_valid = (row_cur_ff != '0) && (col_cur_ff != '0);
      cur_inner = (row_cur_ff >= ROW_W'(2)) && (col_cur_ff >= CW'(2));
      cur_last  = cur_valid && (CFG_W'(row_cur_ff) == h_eff - CFG_W'(1))
                  && (XW'(col_cur_ff) == w_eff - XW'(1));
      keep      = cur_inner && (ctr >= nb_a) && (ctr >= nb_b);
      kept      = keep ? ctr : '0;
      if (!keep) begin
         cls = CLASS_NONE;
      end else if (kept >= high_ff) begin
         cls = CLASS_STRONG;
      end else if (kept >= low_ff) begin
         cls = CLASS_WEAK;
      end else begin
         cls = CLASS_NONE;
      end
   end

   logic               res_valid_ff;
   logic [MAG_W-1:0]   res_kept_ff;
   logic [CLASS_W-1:0] res_class_ff;
   logic               res_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_valid_ff <= cur_valid;
         res_kept_ff  <= kept;
         res_class_ff <= cls;
         res_last_ff  <= cur_last;
      end
   end

   assign result_valid   = res_valid_ff;
   assign kept_magnitude = res_kept_ff;
   assign edge_class     = res_class_ff;
   assign frame_last     = res_last_ff;

endmodule

// ===== rtl/cnms_ctrl.sv =====
// controller: sequences one pixel through the datapath and owns the handshakes
module cnms_ctrl
   import cnms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_CALC;
         ST_CALC:      state_in = status.use_l2 ? ST_ROOT_LOAD : ST_DONE;
         ST_ROOT_LOAD: state_in = ST_ROOT;
         ST_ROOT:      if (!status.root_busy) state_in = ST_DONE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_tready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CALC:      cmd.calc = 1'b1;
         ST_ROOT_LOAD: cmd.root_start = 1'b1;
         ST_DONE:      cmd.finish = out_free;
         default: ;
      endcase
      out_valid_in = cmd.finish ? 1'b1 : (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

// ===== rtl/canny_nonmax_suppress_classify.sv =====
// top level of the canny non-maximum suppression and edge classification block
//
// req channel: one transaction per pixel in raster order, carrying the signed
// horizontal and vertical gradient. rsp channel: exactly one transaction per
// req transaction, describing the window centre one row and one column back.
// csr channel: register writes (0 width, 1 height, 2 l2 select, 3 low and
// 4 high threshold), always ready; write only while the block is idle.
// each pixel steps through capture, gradient arithmetic and window update; in l2
// mode a root load and the bit-pair iterative square root, which resolves one
// root bit per cycle of its GRAD_BITS + 1 bit root, come before the window
// update, and the block waits for the root to finish before it goes on.
// the result lands in an output register, so a new req transaction is taken
// while the previous result still waits; a stalled rsp holds the block in its
// final step until the register frees up.
// reset clears the controller, raster counters, window and registers to their
// defaults; line buffers are not cleared and fill during the first two rows.
module canny_nonmax_suppress_classify
   import cnms_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int GRAD_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: grad_x, grad_y
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [((2*GRAD_BITS+7)/8)*8-1:0] req_tdata,
   // rsp_tdata: kept_magnitude, edge_class
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata,
   // rsp_tuser: result_valid
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   cmd_type            cmd;
   status_type         status;
   logic [MAG_W-1:0]   kept_magnitude;
   logic [CLASS_W-1:0] edge_class;

   // registers always accept a write
   assign csr_ready = 1'b1;

   cnms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cnms_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .GRAD_BITS (GRAD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .grad_x         (req_tdata[GRAD_BITS-1:0]),
      .grad_y         (req_tdata[2*GRAD_BITS-1:GRAD_BITS]),
      .csr_write      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .result_valid   (rsp_tuser),
      .kept_magnitude (kept_magnitude),
      .edge_class     (edge_class),
      .frame_last     (rsp_tlast)
   );

   // pack result, padding to whole bytes
   assign rsp_tdata = {6'b0, edge_class, kept_magnitude};

endmodule

// ===== rtl/cnms_checker.sv =====
// port-level checker for the canny non-maximum suppression block, with its bind
module cnms_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp payload changed");

   // a non-real centre carries all zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 24'd0 && !rsp_tlast)
      else $error("invalid centre with nonzero fields");

   // class code three is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:16] != 2'd3)
      else $error("bad edge class");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("stalled rsp withdrawn");

endmodule

bind canny_nonmax_suppress_classify cnms_checker u_cnms_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/canny_nonmax_suppress_classify_test.sv =====
// self-checking testbench for the canny non-maximum suppression and classification block
module canny_nonmax_suppress_classify_test;
   import cnms_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH = 1024;
   localparam int GRAD_BITS = 15;
   localparam int DATA_W    = ((2*GRAD_BITS+7)/8)*8;
   localparam int LIMIT     = 1500000;
   localparam int SETTLE    = 2*GRAD_BITS + 20;

   // one expected rsp transaction
   typedef struct {
      logic               valid;
      logic [MAG_W-1:0]   kept;
      logic [CLASS_W-1:0] cls;
      logic               last;
   } pixel_result_type;

   typedef struct {
      logic [GRAD_BITS-1:0] gx;
      logic [GRAD_BITS-1:0] gy;
   } grad_pair_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;   // grad_x, grad_y
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;   // kept_magnitude, edge_class
   logic                  rsp_tuser;   // result_valid
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   canny_nonmax_suppress_classify #(.MAX_WIDTH(MAX_WIDTH), .GRAD_BITS(GRAD_BITS)) uut (.*);

   // testbench copy of the registers
   int unsigned cfg_width, cfg_height, cfg_l2, cfg_low, cfg_high;

   // predictor state: line buffers, window, raster position
   logic [MAG_W-1:0] mag_prev_row [MAX_WIDTH];
   logic [MAG_W-1:0] mag_prev2_row [MAX_WIDTH];
   sector_type       sector_row [MAX_WIDTH];
   logic [MAG_W-1:0] win [3][3];
   int unsigned      col_pos, row_pos;
   sector_type       sector_hold;

   grad_pair_type    pixel_queue[$];
   pixel_result_type result_queue[$];
   grad_pair_type    in_flight;
   int unsigned   n_accepted, n_checked, n_errors, n_frames, cycle_count;
   int            idle_mode;   // 0 sender light/receiver heavy, 1 reversed, 2 none

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned floor_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return 32'(res);
   endfunction

   // advance the pixel model by one pixel and queue its result
   task automatic predict_pixel(grad_pair_type p);
      int unsigned w, h, ax, ay, mag, cx, cy;
      logic nx, ny;
      sector_type sec, ctr_sec;
      pixel_result_type r;
      logic [MAG_W-1:0] ctr, na, nb;
      w = clamp_size(cfg_width, MAX_WIDTH);
      h = clamp_size(cfg_height, HEIGHT_MAX);
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      cx = col_pos;
      cy = row_pos;
      nx = p.gx[GRAD_BITS-1];
      ny = p.gy[GRAD_BITS-1];
      ax = nx ? (1 << GRAD_BITS) - p.gx : p.gx;
      ay = ny ? (1 << GRAD_BITS) - p.gy : p.gy;
      mag = cfg_l2 ? floor_root(longint'(ax)*ax + longint'(ay)*ay) : ax + ay;
      if (mag > 16'hFFFF) mag = 16'hFFFF;
      // tangent tests instead of an angle
      if (ay == 0 || (ay << 8) < TAN_LO_Q8*ax) sec = SEC_HORZ;
      else if ((ay << 8) >= TAN_HI_Q8*ax) sec = SEC_VERT;
      else if (nx == ny) sec = SEC_DIAG;
      else sec = SEC_ANTI;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = mag_prev2_row[cx];
      win[1][2] = mag_prev_row[cx];
      win[2][2] = MAG_W'(mag);
      mag_prev2_row[cx] = mag_prev_row[cx];
      mag_prev_row[cx] = MAG_W'(mag);
      ctr_sec = sector_hold;
      sector_hold = sector_row[cx];
      sector_row[cx] = sec;
      r = '{valid: 1'b0, kept: '0, cls: CLASS_NONE, last: 1'b0};
      if (cy >= 1 && cx >= 1) begin
         r.valid = 1'b1;
         if (cy >= 2 && cx >= 2) begin
            ctr = win[1][1];
            case (ctr_sec)
               SEC_HORZ: begin na = win[1][0]; nb = win[1][2]; end
               SEC_VERT: begin na = win[0][1]; nb = win[2][1]; end
               SEC_DIAG: begin na = win[0][0]; nb = win[2][2]; end
               default: begin na = win[0][2]; nb = win[2][0]; end
            endcase
            if (ctr >= na && ctr >= nb) begin
               r.kept = ctr;
               // strong test wins even with crossed thresholds
               if (ctr >= cfg_high) r.cls = CLASS_STRONG;
               else if (ctr >= cfg_low) r.cls = CLASS_WEAK;
            end
         end
         r.last = (cy == h-1 && cx == w-1);
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      result_queue.push_back(r);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("timeout with %0d results outstanding", result_queue.size());
         $display("canny_nonmax_suppress_classify verification failed");
         $finish;
      end
   end

   // idling follows how far the run has got
   always_comb begin
      if (n_accepted < 700) idle_mode = 0;
      else if (n_accepted < 1400) idle_mode = 1;
      else idle_mode = 2;
   end

   // req driver: pops the pixel queue, predicts each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_pixel(in_flight);
            n_accepted <= n_accepted + 1;
         end
         if (pixel_queue.size() != 0 &&
             !(idle_mode == 0 && $urandom_range(99) < 11) &&
             !(idle_mode == 1 && $urandom_range(99) < 84)) begin
            in_flight = pixel_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {{(DATA_W-2*GRAD_BITS){1'b0}}, in_flight.gy, in_flight.gx};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // rsp monitor: compares each transaction with the oldest expected result
   always @(posedge clock) begin
      pixel_result_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case (idle_mode)
            0: rsp_tready <= ($urandom_range(99) >= 84);
            1: rsp_tready <= ($urandom_range(99) >= 11);
            default: rsp_tready <= 1'b1;
         endcase
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               $error("rsp transaction with no expected result");
               n_errors++;
            end else begin
               e = result_queue.pop_front();
               n_checked++;
               if (rsp_tuser !== e.valid) begin
                  $error("result_valid expected %0d actual %0d", e.valid, rsp_tuser);
                  n_errors++;
               end
               if (rsp_tdata[15:0] !== e.kept) begin
                  $error("kept_magnitude expected %0d actual %0d", e.kept, rsp_tdata[15:0]);
                  n_errors++;
               end
               if (rsp_tdata[17:16] !== e.cls) begin
                  $error("edge_class expected %0d actual %0d", e.cls, rsp_tdata[17:16]);
                  n_errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("frame_last expected %0d actual %0d", e.last, rsp_tlast);
                  n_errors++;
               end
            end
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width = val & 11'h7FF;
         CSR_IMAGE_HEIGHT: cfg_height = val & 11'h7FF;
         CSR_USE_L2:       cfg_l2 = val & 1;
         CSR_LOW_THRESH:   cfg_low = val & 16'hFFFF;
         default:          cfg_high = val & 16'hFFFF;
      endcase
   endtask

   // wait for the block to drain before touching registers
   task automatic wait_idle();
      wait (pixel_queue.size() == 0 && !req_tvalid && result_queue.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(int unsigned w, int unsigned h, int unsigned l2,
                             int unsigned lo, int unsigned hi);
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_USE_L2, l2);
      csr_write(CSR_LOW_THRESH, lo);
      csr_write(CSR_HIGH_THRESH, hi);
   endtask

   function automatic logic [GRAD_BITS-1:0] rand_grad();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 4) return GRAD_BITS'($urandom);                            // full range
      if (pick < 8) return GRAD_BITS'($signed($urandom_range(0, 160)) - 80); // near zero
      if (pick == 8) return '0;
      return $urandom_range(1) ? 15'h4000 : 15'h3FFF;      // extremes
   endfunction

   // queue a whole frame so the predictor sees only complete rasters
   task automatic push_frame(bit directed);
      int unsigned n;
      grad_pair_type p;
      n = clamp_size(cfg_width, MAX_WIDTH) * clamp_size(cfg_height, HEIGHT_MAX);
      for (int i = 0; i < n; i++) begin
         if (directed) begin
            case (i % 6)
               0: p = '{gx: 15'h4000, gy: 15'h3FFF};
               1: p = '{gx: 15'h3FFF, gy: 15'h4000};
               2: p = '{gx: '0, gy: '0};
               3: p = '{gx: 15'd100, gy: 15'd41};      // just below the lower tangent
               4: p = '{gx: 15'd100, gy: 15'd242};     // just above the upper tangent
               default: p = '{gx: -15'sd60, gy: 15'd60};
            endcase
         end else begin
            p = '{gx: rand_grad(), gy: rand_grad()};
         end
         pixel_queue.push_back(p);
      end
      n_frames++;
   endtask

   initial begin
      int unsigned sent;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cfg_width = 640; cfg_height = 480; cfg_l2 = 0; cfg_low = 20; cfg_high = 60;
      for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) win[i][j] = '0;
      col_pos = 0; row_pos = 0; sector_hold = SEC_HORZ;
      n_accepted = 0; n_checked = 0; n_errors = 0; n_frames = 0; cycle_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: smallest frame and one a column wider, both magnitude modes, crossed thresholds
      set_config(3, 3, 0, 20, 60);
      push_frame(1'b1);
      set_config(4, 3, 1, 32768, 0);
      push_frame(1'b1);

      // random frames, mostly small, sizes below the minimum included
      sent = 21;
      while (sent < 1450) begin
         set_config($urandom_range(0, 14), $urandom_range(0, 8), $urandom_range(1),
                    $urandom_range(3) == 0 ? $urandom_range(0, 32768) : $urandom_range(0, 200),
                    $urandom_range(3) == 0 ? $urandom_range(0, 32768) : $urandom_range(0, 400));
         sent += clamp_size(cfg_width, MAX_WIDTH) * clamp_size(cfg_height, HEIGHT_MAX);
         push_frame(1'b0);
      end

      wait_idle();
      $display("%0d pixels in %0d frames, %0d results checked, %0d mismatches",
               n_accepted, n_frames, n_checked, n_errors);
      $display("frame sizes up to 14x8 with undersized values clamped, l1 and l2, under stalls");
      if (n_errors == 0) begin
         $display("canny_nonmax_suppress_classify verification clean");
      end else begin
         $display("canny_nonmax_suppress_classify verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/cnms_pkg.sv
rtl/cnms_sqrt.sv
rtl/cnms_dp.sv
rtl/cnms_ctrl.sv
rtl/canny_nonmax_suppress_classify.sv
rtl/cnms_checker.sv
test/canny_nonmax_suppress_classify_test.sv
